[hdl/lcfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_pkg
// Shared types, constants and helper functions for the LED cross-fade and
// rainbow core.
// ----------------------------------------------------------------------------
package lcfr_pkg;

    localparam int MAX_PIXELS_DEF = 64;

    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] REG_FADE_STEP   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_DENSITY     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_PIXEL_COUNT = 2'd2;

    localparam logic [CHAN_W-1:0]  FADE_STEP_RST   = 8'd1;
    localparam logic [CHAN_W-1:0]  DENSITY_RST     = 8'd51;
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 7'd64;

    localparam logic [CHAN_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] WHEEL_SEG = 8'd85;
    localparam logic [CHAN_W-1:0] WHEEL_SEG2 = 8'd170;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic setup;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic last_issue;
        logic pipe_empty;
        logic advance;
    } t_sts;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb wheel_color(input logic [CHAN_W-1:0] pos);
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] q;
        logic [9:0]        p3;
        t_rgb              c;
        p = ~pos;
        if (p < WHEEL_SEG) begin
            q = p;
        end else if (p < WHEEL_SEG2) begin
            q = p - WHEEL_SEG;
        end else begin
            q = p - WHEEL_SEG2;
        end
        p3 = {2'b00, q} + {1'b0, q, 1'b0};
        if (p < WHEEL_SEG) begin
            c.red   = LEVEL_MAX - p3[7:0];
            c.green = '0;
            c.blue  = p3[7:0];
        end else if (p < WHEEL_SEG2) begin
            c.red   = '0;
            c.green = p3[7:0];
            c.blue  = LEVEL_MAX - p3[7:0];
        end else begin
            c.red   = p3[7:0];
            c.green = LEVEL_MAX - p3[7:0];
            c.blue  = '0;
        end
        return c;
    endfunction

    // exact x / 255 for any x up to 65279, which covers every product of two 8-bit values
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

[hdl/lcfr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_ctrl
// Tick sequencer: takes a request, sets up the frame, issues one pixel per
// advancing cycle.
// ----------------------------------------------------------------------------
module lcfr_ctrl
    import lcfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_sts.pipe_empty;
                if (i_in_valid && i_sts.pipe_empty) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.n_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.issue = i_sts.advance;
                if (i_sts.advance && i_sts.last_issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/lcfr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_dp
// Datapath: config registers, fade state, wheel position, and the
// color / multiply / divide pixel pipeline with output register.
// ----------------------------------------------------------------------------
module lcfr_dp
    import lcfr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [CHAN_W-1:0]  i_cfg_wdata,
    input  logic [CHAN_W-1:0]  i_req_red,
    input  logic [CHAN_W-1:0]  i_req_green,
    input  logic [CHAN_W-1:0]  i_req_blue,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic [CHAN_W-1:0]  o_out_red,
    output logic [CHAN_W-1:0]  o_out_green,
    output logic [CHAN_W-1:0]  o_out_blue,
    output logic               o_last_pixel
);

    localparam int CW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [COUNT_W-1:0] N_MAX = COUNT_W'(MAX_PIXELS);

    logic [CHAN_W-1:0]  r_fade_step;
    logic [CHAN_W-1:0]  r_density;
    logic [COUNT_W-1:0] r_pixel_count;

    logic [CHAN_W-1:0]  r_level;
    logic               r_fading;
    t_rgb               r_shown;
    logic [CHAN_W-1:0]  r_offset;

    logic [COUNT_W-1:0] r_n;
    logic [CW-1:0]      r_idx;
    logic [CHAN_W-1:0]  r_pos;

    logic               r_s1_valid;
    logic               r_s1_last;
    logic [CW-1:0]      r_s1_idx;
    t_rgb               r_s1_rgb;

    logic               r_s2_valid;
    logic               r_s2_last;
    logic [CW-1:0]      r_s2_idx;
    logic [15:0]        r_s2_red;
    logic [15:0]        r_s2_green;
    logic [15:0]        r_s2_blue;

    logic               r_out_valid;
    logic               r_out_last;
    logic [CW-1:0]      r_out_idx;
    t_rgb               r_out_rgb;

    t_rgb               req;
    logic               differs;
    logic               fade_now;
    logic [CHAN_W:0]    up_sum;
    logic               rainbow;
    logic [COUNT_W-1:0] n_count;
    logic               advance;
    t_rgb               s1_color;

    assign req      = '{red: i_req_red, green: i_req_green, blue: i_req_blue};
    assign differs  = (req != r_shown);
    assign fade_now = r_fading || differs;
    assign up_sum   = {1'b0, r_level} + {1'b0, r_fade_step};
    assign rainbow  = (r_shown.red == '0) && (r_shown.green == '0)
                   && (r_shown.blue == 8'd1);
    assign n_count  = (r_pixel_count > N_MAX) ? N_MAX : r_pixel_count;
    assign advance  = !r_out_valid || !i_out_stall;
    assign s1_color = rainbow ? wheel_color(r_pos) : r_shown;

    assign o_sts.n_zero     = (n_count == '0);
    assign o_sts.last_issue = (COUNT_W'(r_idx) + COUNT_W'(1)) == r_n;
    assign o_sts.pipe_empty = !r_s1_valid && !r_s2_valid;
    assign o_sts.advance    = advance;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_step   <= FADE_STEP_RST;
            r_density     <= DENSITY_RST;
            r_pixel_count <= PIXEL_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FADE_STEP:   r_fade_step   <= i_cfg_wdata;
                REG_DENSITY:     r_density     <= i_cfg_wdata;
                REG_PIXEL_COUNT: r_pixel_count <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_fading <= 1'b1;
            r_shown  <= '0;
            r_offset <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (fade_now) begin
                    if (r_level <= r_fade_step) begin
                        r_level  <= '0;
                        r_fading <= 1'b0;
                        r_shown  <= req;
                    end else begin
                        r_level  <= r_level - r_fade_step;
                        r_fading <= 1'b1;
                    end
                end else begin
                    r_level <= up_sum[CHAN_W] ? LEVEL_MAX : up_sum[CHAN_W-1:0];
                end
            end
            if (i_cmd.setup && rainbow && !r_fading) begin
                r_offset <= r_offset + 8'd1;
            end
        end
    end

    // pixel counter and wheel position
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_n   <= n_count;
            r_idx <= '0;
            r_pos <= r_offset;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + CW'(1);
            r_pos <= r_pos + r_density;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_cmd.issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_last  <= o_sts.last_issue;
            r_s1_idx   <= r_idx;
            r_s1_rgb   <= s1_color;

            r_s2_last  <= r_s1_last;
            r_s2_idx   <= r_s1_idx;
            r_s2_red   <= {8'd0, r_s1_rgb.red}   * {8'd0, r_level};
            r_s2_green <= {8'd0, r_s1_rgb.green} * {8'd0, r_level};
            r_s2_blue  <= {8'd0, r_s1_rgb.blue}  * {8'd0, r_level};

            r_out_last      <= r_s2_last;
            r_out_idx       <= r_s2_idx;
            r_out_rgb.red   <= div255(r_s2_red);
            r_out_rgb.green <= div255(r_s2_green);
            r_out_rgb.blue  <= div255(r_s2_blue);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = INDEX_W'(r_out_idx);
    assign o_out_red     = r_out_rgb.red;
    assign o_out_green   = r_out_rgb.green;
    assign o_out_blue    = r_out_rgb.blue;
    assign o_last_pixel  = r_out_last;

`ifndef SYNTHESIS
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (!r_s1_valid && !r_s2_valid))
        else $error("request taken while pixels in flight");

    a_level_hold: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && !$past(i_cmd.accept)) |-> $stable(r_level))
        else $error("level changed outside a request");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (COUNT_W'(r_idx) < r_n))
        else $error("pixel issued beyond frame length");
`endif

endmodule

[hdl/led_color_fade_rainbow_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_fade_rainbow_core
// LED strip cross-fade with color-wheel rainbow, one frame per refresh tick.
// ----------------------------------------------------------------------------
// Each accepted request is one refresh tick. It updates the fade level in the
// accept cycle, passes through a setup state, then issues one pixel per cycle,
// while the output is not stalled, from a pixel counter into a three-stage pipe
// (wheel color, brightness multiply, divide by 255). A tick whose pixel_count
// is zero issues no pixels. The next request is taken once the pipe has
// drained to the output register.
module led_color_fade_rainbow_core
    import lcfr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ADDR_W-1:0]  i_cfg_addr,
    input  logic [CHAN_W-1:0]  i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CHAN_W-1:0]  i_req_red,
    input  logic [CHAN_W-1:0]  i_req_green,
    input  logic [CHAN_W-1:0]  i_req_blue,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic [CHAN_W-1:0]  o_out_red,
    output logic [CHAN_W-1:0]  o_out_green,
    output logic [CHAN_W-1:0]  o_out_blue,
    output logic               o_last_pixel
);

    t_cmd cmd;
    t_sts sts;

    lcfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lcfr_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_red     (i_req_red),
        .i_req_green   (i_req_green),
        .i_req_blue    (i_req_blue),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_index (o_pixel_index),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED cross-fade and rainbow core. A directed
// table walks the fade, latch, rainbow and register corner cases, then
// random phases with fresh register settings drive mostly well-formed fade
// sequences. Every pixel is checked against an in-bench model of the fade
// level, the latched color and the color wheel, under random idle bursts on
// both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import lcfr_pkg::*;

    localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES        = 10;
    localparam int PHASE_TICKS   = 21;
    localparam int HOLD_PHASE    = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic { ROW_REG, ROW_TICK } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [CHAN_W-1:0] wdata;
        t_rgb              req;
        logic              fixed;
        t_rgb              fixed_color;
    } t_row;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        t_rgb               color;
        logic               last;
    } t_pixel;

    // fixed colors only where the frame is flat and obvious
    localparam t_row SCRIPT [0:37] = '{
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000000, 1'b1, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd255, 24'h000000, 1'b0, 24'h000000},
        '{ROW_REG,  REG_PIXEL_COUNT, 8'd4,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'hffffff, 1'b1, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'hffffff, 1'b1, 24'hffffff},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b1, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_DENSITY,     8'd0,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_DENSITY,     8'd255, 24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_PIXEL_COUNT, 8'd0,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_PIXEL_COUNT, 8'd127, 24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_PIXEL_COUNT, 8'd3,   24'h000000, 1'b0, 24'h000000},
        '{ROW_REG,  REG_SPARE,       8'd0,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd0,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd100, 24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b1, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd0,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b1, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd255, 24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h000001, 1'b0, 24'h000000},
        '{ROW_REG,  REG_FADE_STEP,   8'd100, 24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b1, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'h0a141e, 1'b1, 24'h0a141e},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'hff8000, 1'b0, 24'h000000},
        '{ROW_TICK, REG_FADE_STEP,   8'd0,   24'hff8000, 1'b0, 24'h000000}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [ADDR_W-1:0]  i_cfg_addr;
    logic [CHAN_W-1:0]  i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CHAN_W-1:0]  i_req_red;
    logic [CHAN_W-1:0]  i_req_green;
    logic [CHAN_W-1:0]  i_req_blue;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [INDEX_W-1:0] o_pixel_index;
    logic [CHAN_W-1:0]  o_out_red;
    logic [CHAN_W-1:0]  o_out_green;
    logic [CHAN_W-1:0]  o_out_blue;
    logic               o_last_pixel;

    // model of the block
    int          step_cfg;
    int          density_cfg;
    int          count_cfg;
    int          level;
    bit          fading;
    t_rgb        shown;
    int          wheel_offset;

    t_pixel      pending_pixels[$];
    t_rgb        last_req;
    int          mismatches;
    bit          quiet;
    bit          hold_off_req;

    led_color_fade_rainbow_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_red     (i_req_red),
        .i_req_green   (i_req_green),
        .i_req_blue    (i_req_blue),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_index (o_pixel_index),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_last_pixel  (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_rgb wheel_at(input int pos);
        int   p;
        t_rgb c;
        p = 255 - (pos & 255);
        if (p < 85) begin
            c.red   = 8'(255 - 3 * p);
            c.green = 8'd0;
            c.blue  = 8'(3 * p);
        end else if (p < 170) begin
            p -= 85;
            c.red   = 8'd0;
            c.green = 8'(3 * p);
            c.blue  = 8'(255 - 3 * p);
        end else begin
            p -= 170;
            c.red   = 8'(3 * p);
            c.green = 8'(255 - 3 * p);
            c.blue  = 8'd0;
        end
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] c);
        return 8'((int'(c) * level) / 255);
    endfunction

    // one refresh tick: fade update, frame of pixels, wheel advance
    task automatic advance_frame(input t_rgb req, input bit fixed, input t_rgb fixed_color);
        int     n;
        bit     rainbow;
        t_rgb   c;
        t_pixel px;
        if (req != shown) fading = 1'b1;
        if (fading) begin
            level -= step_cfg;
            if (level <= 0) begin
                level  = 0;
                fading = 1'b0;
                shown  = req;
            end
        end else begin
            level += step_cfg;
            if (level >= 255) level = 255;
        end
        n = (count_cfg > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : count_cfg;
        rainbow = (shown == 24'h000001);
        for (int i = 0; i < n; i++) begin
            c = rainbow ? wheel_at(i * density_cfg + wheel_offset) : shown;
            px.index       = INDEX_W'(i);
            px.color.red   = dim(c.red);
            px.color.green = dim(c.green);
            px.color.blue  = dim(c.blue);
            px.last        = (i == n - 1);
            if (fixed) px.color = fixed_color;
            pending_pixels.push_back(px);
        end
        if (rainbow && !fading) wheel_offset = (wheel_offset + 1) & 255;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CHAN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            REG_FADE_STEP:   step_cfg    = int'(data);
            REG_DENSITY:     density_cfg = int'(data);
            REG_PIXEL_COUNT: count_cfg   = int'(data[COUNT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic send_tick(input t_rgb req, input bit fixed, input t_rgb fixed_color);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_red   <= req.red;
        i_req_green <= req.green;
        i_req_blue  <= req.blue;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_frame(req, fixed, fixed_color);
        last_req = req;
    endtask

    // block idle: nothing pending, plus margin for frames with no pixels
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with nothing pending", int'(o_pixel_index), -1);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_index !== want.index)
                    report_mismatch("pixel_index", int'(o_pixel_index), int'(want.index));
                if (o_out_red !== want.color.red)
                    report_mismatch("out_red", int'(o_out_red), int'(want.color.red));
                if (o_out_green !== want.color.green)
                    report_mismatch("out_green", int'(o_out_green), int'(want.color.green));
                if (o_out_blue !== want.color.blue)
                    report_mismatch("out_blue", int'(o_out_blue), int'(want.color.blue));
                if (o_last_pixel !== want.last)
                    report_mismatch("last_pixel", int'(o_last_pixel), int'(want.last));
            end
        end
    end

    initial begin
        t_rgb        req;
        int          sel;
        logic [7:0]  pick;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_req_red    = '0;
        i_req_green  = '0;
        i_req_blue   = '0;
        step_cfg     = int'(FADE_STEP_RST);
        density_cfg  = int'(DENSITY_RST);
        count_cfg    = int'(PIXEL_COUNT_RST);
        level        = 0;
        fading       = 1'b1;
        shown        = '0;
        wheel_offset = 0;
        last_req     = '0;
        mismatches   = 0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[k]) begin
            if (SCRIPT[k].kind == ROW_REG) begin
                settle();
                write_reg(SCRIPT[k].addr, SCRIPT[k].wdata);
            end else begin
                send_tick(SCRIPT[k].req, SCRIPT[k].fixed, SCRIPT[k].fixed_color);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == PHASES - 1) quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: pick = 8'd0;
                1: pick = 8'd1;
                2: pick = 8'd255;
                default: pick = 8'($urandom_range(1, 255));
            endcase
            write_reg(REG_FADE_STEP, pick);
            case ($urandom_range(0, 3))
                0: pick = 8'd0;
                1: pick = 8'd255;
                default: pick = 8'($urandom);
            endcase
            write_reg(REG_DENSITY, pick);
            case ($urandom_range(0, 9))
                0: pick = 8'd0;
                1: pick = 8'd64;
                2: pick = 8'($urandom_range(65, 255));
                default: pick = 8'($urandom_range(1, 8));
            endcase
            if (ph == HOLD_PHASE) pick = 8'd16;
            write_reg(REG_PIXEL_COUNT, pick);
            if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, 8'($urandom));
            if (ph == HOLD_PHASE) hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    req = 24'h000001;
                else if (sel < 7)
                    req = last_req;
                else if (sel < 9)
                    req = 24'($urandom);
                else
                    req = 24'($urandom_range(0, 3)) | (24'($urandom_range(0, 1)) << 16);
                send_tick(req, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/lcfr_pkg.sv
hdl/lcfr_ctrl.sv
hdl/lcfr_dp.sv
hdl/led_color_fade_rainbow_core.sv
sim/tb_top.sv
